FILE: sv/sptc_pkg.sv
// ----------------------------------------------------------------------------
// sptc_pkg: shared types, constants and the azimuth table builder
// Field widths, stream packing, the Q1.15 sine series used to fill the
// angle tables at elaboration, and the trig bundle type.
// ----------------------------------------------------------------------------
package sptc_pkg;

   // field widths
   localparam int StepBits  = 10;
   localparam int RowBits   = 10;
   localparam int RangeBits = 16;
   localparam int SlotBits  = 20;
   localparam int ColorBits = 24;
   localparam int CoordBits = 17;
   localparam int TrigBits  = 16;

   // stream packing
   localparam int ReqDataBits = 80;
   localparam int RspDataBits = 96;

   // parameter defaults
   localparam int RowCountDefault  = 720;
   localparam int IndexBitsDefault = 20;

   // table depths
   localparam int StepDepth = 1 << StepBits;
   localparam int RowDepth  = 1 << RowBits;

   // angle constants: pi/2 in Q40, azimuth of 9 units per step, 1800 units a quarter
   localparam longint unsigned PiHalfQ40    = 64'h1921FB54443;
   localparam longint unsigned ThetaQuarter = 64'd1800;
   localparam longint unsigned ThetaTurn    = 64'd4 * ThetaQuarter;
   localparam longint unsigned ThetaStep    = 64'd9;

   typedef logic signed [TrigBits-1:0] trig_type;
   typedef logic [2*TrigBits-1:0]      trig_pair_type;
   typedef trig_pair_type              theta_rom_type [StepDepth];
   typedef trig_pair_type              phi_rom_type [RowDepth];

   // trig values for one item, sine and cosine of both angles
   typedef struct packed {
      trig_type sin_theta;
      trig_type cos_theta;
      trig_type sin_phi;
      trig_type cos_phi;
   } trig_set_type;

   // (a * b) >> 40 for operands below 2^41
   function automatic longint unsigned mul_q40(input longint unsigned a,
                                               input longint unsigned b);
      longint unsigned hi;
      longint unsigned lo;
      hi = (a * (b >> 20)) >> 20;
      lo = (a * (b & 64'hFFFFF)) >> 40;
      return hi + lo;
   endfunction

   // sin(x) for 0 <= x <= pi/2 (x in Q40), rounded to Q1.15, capped at 32767
   function automatic logic [TrigBits-1:0] taylor_sine(input longint unsigned x);
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned v;
      x2   = mul_q40(x, x);
      term = x;
      sum  = x;
      term = mul_q40(term, x2) / 6;   sum = sum - term;
      term = mul_q40(term, x2) / 20;  sum = sum + term;
      term = mul_q40(term, x2) / 42;  sum = sum - term;
      term = mul_q40(term, x2) / 72;  sum = sum + term;
      term = mul_q40(term, x2) / 110; sum = sum - term;
      term = mul_q40(term, x2) / 156; sum = sum + term;
      term = mul_q40(term, x2) / 210; sum = sum - term;
      term = mul_q40(term, x2) / 272; sum = sum + term;
      v = (sum + (64'd1 << 24)) >> 25;
      return (v > 64'd32767) ? TrigBits'(32767) : v[TrigBits-1:0];
   endfunction

   // signed sine of n azimuth units, quadrant folded onto the first quarter
   function automatic trig_type theta_sine(input longint unsigned n);
      longint unsigned m;
      longint unsigned qd;
      longint unsigned r;
      logic [TrigBits-1:0] mag;
      m  = n % ThetaTurn;
      qd = m / ThetaQuarter;
      r  = m % ThetaQuarter;
      if (qd[0]) begin
         mag = taylor_sine(((ThetaQuarter - r) * PiHalfQ40) / ThetaQuarter);
      end else begin
         mag = taylor_sine((r * PiHalfQ40) / ThetaQuarter);
      end
      return (qd >= 64'd2) ? -$signed(mag) : $signed(mag);
   endfunction

   // azimuth table: {sine, cosine} for every step position
   function automatic theta_rom_type build_theta_rom();
      theta_rom_type rom;
      longint unsigned n;
      for (int s = 0; s < StepDepth; s++) begin
         n = ThetaStep * 64'(s);
         rom[s] = {theta_sine(n), theta_sine(n + ThetaQuarter)};
      end
      return rom;
   endfunction

endpackage

FILE: sv/sptc_trig_rom.sv
// ----------------------------------------------------------------------------
// sptc_trig_rom: azimuth and elevation sine/cosine lookup
// Two 1024 x 32 read-only tables, one addressed by step position and one by
// camera row, filled at elaboration, with registered read data.
// ----------------------------------------------------------------------------
module sptc_trig_rom #(
   parameter int ROW_COUNT = sptc_pkg::RowCountDefault
) (
   input  logic                          clock,
   input  logic                          read_en,
   input  logic [sptc_pkg::StepBits-1:0] step_position,
   input  logic [sptc_pkg::RowBits-1:0]  camera_row,
   output sptc_pkg::trig_set_type        trig_out
);
   import sptc_pkg::*;

   // elevation in units where 360 * ROW_COUNT make a quarter turn
   localparam longint unsigned PhiQuarter = 64'(360 * ROW_COUNT);
   localparam longint unsigned PhiTurn    = 64'd4 * PhiQuarter;
   localparam longint unsigned PhiBase    = 64'(291 * ROW_COUNT);
   localparam longint unsigned PhiRowStep = 64'd138;

   // signed sine of n elevation units
   function automatic trig_type phi_sine(input longint unsigned n);
      longint unsigned m;
      longint unsigned qd;
      longint unsigned r;
      logic [TrigBits-1:0] mag;
      m  = n % PhiTurn;
      qd = m / PhiQuarter;
      r  = m % PhiQuarter;
      if (qd[0]) begin
         mag = taylor_sine(((PhiQuarter - r) * PiHalfQ40) / PhiQuarter);
      end else begin
         mag = taylor_sine((r * PiHalfQ40) / PhiQuarter);
      end
      return (qd >= 64'd2) ? -$signed(mag) : $signed(mag);
   endfunction

   // elevation table: {sine, cosine} for every row code
   function automatic phi_rom_type build_phi_rom();
      phi_rom_type rom;
      longint unsigned n;
      for (int r = 0; r < RowDepth; r++) begin
         n = PhiBase + PhiRowStep * 64'(r);
         rom[r] = {phi_sine(n), phi_sine(n + PhiQuarter)};
      end
      return rom;
   endfunction

   localparam theta_rom_type ThetaRom = build_theta_rom();
   localparam phi_rom_type   PhiRom   = build_phi_rom();

   trig_pair_type theta_pair_ff;
   trig_pair_type phi_pair_ff;

   // registered table reads
   always_ff @(posedge clock) begin
      if (read_en) begin
         theta_pair_ff <= ThetaRom[step_position];
         phi_pair_ff   <= PhiRom[camera_row];
      end
   end

   assign trig_out.sin_theta = theta_pair_ff[2*TrigBits-1:TrigBits];
   assign trig_out.cos_theta = theta_pair_ff[TrigBits-1:0];
   assign trig_out.sin_phi   = phi_pair_ff[2*TrigBits-1:TrigBits];
   assign trig_out.cos_phi   = phi_pair_ff[TrigBits-1:0];

endmodule

FILE: sv/scan_point_to_cartesian.sv
// ----------------------------------------------------------------------------
// scan_point_to_cartesian: scanner sample to Cartesian point
// Four-stage pipeline: trig lookup, range products, azimuth products with
// y rounding, x/z rounding and saturation. Index and color pass along.
// ----------------------------------------------------------------------------
// The block takes one sample per clock unless rsp stalls; a stall on rsp holds
// the pipeline in place and only backs up to req_tready once all four stages
// hold a point. Each stage holds at most one table read or one multiply of up
// to 33 x 16 per coordinate, so the rate stays one point per unstalled cycle.
// Azimuth and elevation tables are 1024 x 32 constant memories, read once per
// point.
module scan_point_to_cartesian #(
   parameter int ROW_COUNT  = sptc_pkg::RowCountDefault,
   parameter int INDEX_BITS = sptc_pkg::IndexBitsDefault
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata, lsb up: step_position[10], camera_row[10], range_value[16],
   // point_index[20], red_in[8], green_in[8], blue_in[8]
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [sptc_pkg::ReqDataBits-1:0] req_tdata,
   // rsp_tdata, lsb up: x_coord[17], y_coord[17], z_coord[17], point_slot[20],
   // red_out[8], green_out[8], blue_out[8], zero pad[1]
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [sptc_pkg::RspDataBits-1:0] rsp_tdata
);
   import sptc_pkg::*;

   localparam int XzProdBits = 49;
   localparam int YProdBits  = 33;
   localparam int XzShift    = 30;
   localparam int YShift     = 15;
   localparam logic [CoordBits-1:0] CoordFloor = {1'b1, {(CoordBits-1){1'b0}}};
   localparam logic [SlotBits-1:0]  SlotMask = (INDEX_BITS >= SlotBits) ?
      {SlotBits{1'b1}} : SlotBits'((64'd1 << INDEX_BITS) - 64'd1);

   // round half away from zero, saturate to 65535, encode two's complement
   function automatic logic [CoordBits-1:0] round_xz(input logic signed [XzProdBits-1:0] p);
      logic [XzProdBits-1:0] m;
      logic [XzProdBits-1:0] q;
      logic [CoordBits-1:0]  mag;
      m = p[XzProdBits-1] ? XzProdBits'(-p) : XzProdBits'(p);
      q = (m + (XzProdBits'(1) << (XzShift - 1))) >> XzShift;
      mag = (q > XzProdBits'(65535)) ? CoordBits'(65535) : q[CoordBits-1:0];
      return p[XzProdBits-1] ? (~mag + CoordBits'(1)) : mag;
   endfunction

   function automatic logic [CoordBits-1:0] round_y(input logic signed [YProdBits-1:0] p);
      logic [YProdBits-1:0] m;
      logic [YProdBits-1:0] q;
      logic [CoordBits-1:0] mag;
      m = p[YProdBits-1] ? YProdBits'(-p) : YProdBits'(p);
      q = (m + (YProdBits'(1) << (YShift - 1))) >> YShift;
      mag = (q > YProdBits'(65535)) ? CoordBits'(65535) : q[CoordBits-1:0];
      return p[YProdBits-1] ? (~mag + CoordBits'(1)) : mag;
   endfunction

   // stage enables
   logic en1, en2, en3, en4;

   // stage 1: table lookup
   logic                   v1_ff, v1_in;
   logic [RangeBits-1:0]   rho1_ff;
   logic [SlotBits-1:0]    slot1_ff;
   logic [ColorBits-1:0]   color1_ff;
   trig_set_type           trig1;

   // stage 2: range products
   logic                         v2_ff, v2_in;
   logic signed [YProdBits-1:0]  rs2_ff, rs2_in;
   logic signed [YProdBits-1:0]  yprod2_ff, yprod2_in;
   trig_type                     sin_th2_ff, cos_th2_ff;
   logic [SlotBits-1:0]          slot2_ff;
   logic [ColorBits-1:0]         color2_ff;

   // stage 3: azimuth products, y rounding
   logic                         v3_ff, v3_in;
   logic signed [XzProdBits-1:0] xprod3_ff, xprod3_in;
   logic signed [XzProdBits-1:0] zprod3_ff, zprod3_in;
   logic [CoordBits-1:0]         y3_ff, y3_in;
   logic [SlotBits-1:0]          slot3_ff;
   logic [ColorBits-1:0]         color3_ff;

   // stage 4: x/z rounding, output register
   logic                  v4_ff, v4_in;
   logic [CoordBits-1:0]  x4_ff, x4_in;
   logic [CoordBits-1:0]  y4_ff;
   logic [CoordBits-1:0]  z4_ff, z4_in;
   logic [SlotBits-1:0]   slot4_ff;
   logic [ColorBits-1:0]  color4_ff;

   // a stage may load when empty or when the next one loads
   always_comb begin
      en4 = !v4_ff || rsp_tready;
      en3 = !v3_ff || en4;
      en2 = !v2_ff || en3;
      en1 = !v1_ff || en2;
   end

   assign req_tready = en1;

   // valid bits move with the data
   always_comb begin
      v1_in = en1 ? req_tvalid : v1_ff;
      v2_in = en2 ? v1_ff : v2_ff;
      v3_in = en3 ? v2_ff : v3_ff;
      v4_in = en4 ? v3_ff : v4_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
      end
   end

   // sine/cosine lookup for both angles
   sptc_trig_rom #(
      .ROW_COUNT(ROW_COUNT)
   ) u_trig_rom (
      .clock        (clock),
      .read_en      (en1),
      .step_position(req_tdata[9:0]),
      .camera_row   (req_tdata[19:10]),
      .trig_out     (trig1)
   );

   always_ff @(posedge clock) begin
      if (en1) begin
         rho1_ff   <= req_tdata[35:20];
         slot1_ff  <= req_tdata[55:36] & SlotMask;
         color1_ff <= req_tdata[79:56];
      end
   end

   // rho * sin(phi) and rho * cos(phi)
   always_comb begin
      rs2_in    = $signed({1'b0, rho1_ff}) * trig1.sin_phi;
      yprod2_in = $signed({1'b0, rho1_ff}) * trig1.cos_phi;
   end

   always_ff @(posedge clock) begin
      if (en2) begin
         rs2_ff     <= rs2_in;
         yprod2_ff  <= yprod2_in;
         sin_th2_ff <= trig1.sin_theta;
         cos_th2_ff <= trig1.cos_theta;
         slot2_ff   <= slot1_ff;
         color2_ff  <= color1_ff;
      end
   end

   // azimuth products, y rounded from its Q15 product
   always_comb begin
      xprod3_in = rs2_ff * sin_th2_ff;
      zprod3_in = rs2_ff * cos_th2_ff;
      y3_in     = round_y(yprod2_ff);
   end

   always_ff @(posedge clock) begin
      if (en3) begin
         xprod3_ff <= xprod3_in;
         zprod3_ff <= zprod3_in;
         y3_ff     <= y3_in;
         slot3_ff  <= slot2_ff;
         color3_ff <= color2_ff;
      end
   end

   // x and z rounded from their Q30 products
   always_comb begin
      x4_in = round_xz(xprod3_ff);
      z4_in = round_xz(zprod3_ff);
   end

   always_ff @(posedge clock) begin
      if (en4) begin
         x4_ff     <= x4_in;
         y4_ff     <= y3_ff;
         z4_ff     <= z4_in;
         slot4_ff  <= slot3_ff;
         color4_ff <= color3_ff;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {1'b0, color4_ff, slot4_ff, z4_ff, y4_ff, x4_ff};

   // back pressure reaches the input only with every stage full
   a_full_when_blocked : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("input blocked with an empty pipeline stage");

   // a point leaving stage 3 lands in the output register
   a_stage4_loads : assert property (@(posedge clock) disable iff (reset)
      (v3_ff && en4) |=> v4_ff)
      else $error("point lost between stage 3 and output");

   // zero range yields zero products
   a_zero_range : assert property (@(posedge clock) disable iff (reset)
      (v1_ff && en2 && rho1_ff == '0) |=> (rs2_ff == '0 && yprod2_ff == '0))
      else $error("nonzero product from zero range");

   // saturation keeps coordinates above the most negative code
   a_coord_floor : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (x4_ff != CoordFloor && y4_ff != CoordFloor && z4_ff != CoordFloor))
      else $error("coordinate outside saturation range");

endmodule
